### sv/swr_pkg.sv
// Shared types and constants for the stream word replace unit.
// No dependencies; imported by every module of the block.
package swr_pkg;

   localparam int MAX_SEARCH_LEN  = 16;
   localparam int MAX_REPLACE_LEN = 16;

   // window / word indexing and byte counts
   localparam int SIDX_W = (MAX_SEARCH_LEN > 1) ? $clog2(MAX_SEARCH_LEN) : 1;
   localparam int RIDX_W = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1;
   localparam int CNT_W  = $clog2(((MAX_SEARCH_LEN > MAX_REPLACE_LEN) ?
                                   MAX_SEARCH_LEN : MAX_REPLACE_LEN) + 1);

   // register file geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_REG_W  = 5;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef logic [7:0] byte_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEARCH_LENGTH  = 3'd0,
      CSR_REPLACE_LENGTH = 3'd1,
      CSR_SEARCH_LOW     = 3'd2,
      CSR_SEARCH_HIGH    = 3'd3,
      CSR_REPLACE_LOW    = 3'd4,
      CSR_REPLACE_HIGH   = 3'd5
   } csr_index_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [CNT_W-1:0]                 search_len;
      logic [CNT_W-1:0]                 replace_len;
      byte_type [MAX_SEARCH_LEN-1:0]    search_word;
      byte_type [MAX_REPLACE_LEN-1:0]   replace_word;
   } cfg_type;

   // one classified input item, expanded into results by the back end
   typedef struct packed {
      logic                             eot;
      logic                             bare;
      logic                             head_replace;
      byte_type                         head_byte;
      logic [CNT_W-1:0]                 head_count;
      logic [CNT_W-1:0]                 last_idx;
      byte_type [MAX_SEARCH_LEN-1:0]    flush_bytes;
   } entry_type;

endpackage

### sv/swr_csr.sv
// Configuration registers of the stream word replace unit.
// Depends on swr_pkg; presents clamped lengths and the two words.
module swr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [swr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output swr_pkg::cfg_type                  cfg,
   output logic                              window_clear
);
   import swr_pkg::*;

   logic [LEN_REG_W-1:0]  search_length_ff;
   logic [LEN_REG_W-1:0]  replace_length_ff;
   logic [CSR_DATA_W-1:0] search_low_ff;
   logic [CSR_DATA_W-1:0] search_high_ff;
   logic [CSR_DATA_W-1:0] replace_low_ff;
   logic [CSR_DATA_W-1:0] replace_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_length_ff  <= LEN_REG_W'(1);
         replace_length_ff <= '0;
         search_low_ff     <= '0;
         search_high_ff    <= '0;
         replace_low_ff    <= '0;
         replace_high_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEARCH_LENGTH:  search_length_ff  <= csr_write_data[LEN_REG_W-1:0];
            CSR_REPLACE_LENGTH: replace_length_ff <= csr_write_data[LEN_REG_W-1:0];
            CSR_SEARCH_LOW:     search_low_ff     <= csr_write_data;
            CSR_SEARCH_HIGH:    search_high_ff    <= csr_write_data;
            CSR_REPLACE_LOW:    replace_low_ff    <= csr_write_data;
            CSR_REPLACE_HIGH:   replace_high_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // new search length drops whatever the window holds
   assign window_clear = csr_write_enable &&
                         (csr_index == CSR_IDX_W'(CSR_SEARCH_LENGTH));

   always_comb begin
      if (search_length_ff == '0) begin
         cfg.search_len = CNT_W'(1);
      end else if (CNT_W'(search_length_ff) > CNT_W'(MAX_SEARCH_LEN)) begin
         cfg.search_len = CNT_W'(MAX_SEARCH_LEN);
      end else begin
         cfg.search_len = CNT_W'(search_length_ff);
      end
      if (CNT_W'(replace_length_ff) > CNT_W'(MAX_REPLACE_LEN)) begin
         cfg.replace_len = CNT_W'(MAX_REPLACE_LEN);
      end else begin
         cfg.replace_len = CNT_W'(replace_length_ff);
      end
      cfg.search_word  = {search_high_ff, search_low_ff};
      cfg.replace_word = {replace_high_ff, replace_low_ff};
   end

endmodule

### sv/swr_front.sv
// Front end: holds the byte window, matches it against the search word and turns
// each accepted byte with results or the end flag into one queue entry. Depends on swr_pkg.
module swr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  swr_pkg::cfg_type      cfg,
   input  logic                  window_clear,
   input  logic                  req_fire,
   input  swr_pkg::byte_type     req_text_byte,
   input  logic                  req_end_of_text,
   output swr_pkg::entry_type    entry,
   output logic                  entry_push
);
   import swr_pkg::*;

   byte_type             window_ff [MAX_SEARCH_LEN];
   byte_type             window_in [MAX_SEARCH_LEN];
   logic [CNT_W-1:0]     fill_ff;
   logic [CNT_W-1:0]     fill_in;

   byte_type             win_new   [MAX_SEARCH_LEN];
   byte_type             win_shift [MAX_SEARCH_LEN];
   logic [MAX_SEARCH_LEN-1:0] byte_hit;
   logic                 window_full;
   logic                 word_match;
   logic [CNT_W-1:0]     post_fill;
   logic [CNT_W-1:0]     flush_count;
   logic [CNT_W-1:0]     total;

   always_comb begin
      win_new = window_ff;
      win_new[fill_ff[SIDX_W-1:0]] = req_text_byte;
      for (int i = 0; i < MAX_SEARCH_LEN; i++) begin
         byte_hit[i] = (CNT_W'(i) >= cfg.search_len) ||
                       (win_new[i] == cfg.search_word[i]);
      end
      for (int i = 0; i < MAX_SEARCH_LEN - 1; i++) begin
         win_shift[i] = win_new[i+1];
      end
      win_shift[MAX_SEARCH_LEN-1] = win_new[MAX_SEARCH_LEN-1];

      window_full = (CNT_W'(fill_ff + 1'b1) == cfg.search_len);
      word_match  = &byte_hit;

      entry.eot          = req_end_of_text;
      entry.head_byte    = win_new[0];
      entry.head_replace = 1'b0;
      entry.head_count   = '0;
      window_in          = win_new;
      post_fill          = CNT_W'(fill_ff + 1'b1);
      if (window_full && word_match) begin
         entry.head_replace = 1'b1;
         entry.head_count   = cfg.replace_len;
         post_fill          = '0;
      end else if (window_full) begin
         entry.head_count   = CNT_W'(1);
         window_in          = win_shift;
         post_fill          = CNT_W'(cfg.search_len - 1'b1);
      end

      flush_count = req_end_of_text ? post_fill : '0;
      total       = CNT_W'(entry.head_count + flush_count);
      for (int i = 0; i < MAX_SEARCH_LEN; i++) begin
         entry.flush_bytes[i] = window_in[i];
      end
      entry.bare     = req_end_of_text && (total == '0);
      entry.last_idx = (total == '0) ? '0 : CNT_W'(total - 1'b1);
      entry_push     = req_fire && ((total != '0) || req_end_of_text);
      fill_in        = req_end_of_text ? '0 : post_fill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (window_clear) begin
         fill_ff <= '0;
      end else if (req_fire) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_ff <= window_in;
      end
   end

   // window never reaches the search length between bytes
   a_fill_below_len: assert property (@(posedge clock) disable iff (reset)
      fill_ff < cfg.search_len)
      else $error("window fill reached search length");

   // end of text always leaves an empty window
   a_eot_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_end_of_text) |=> (fill_ff == '0))
      else $error("window not empty after end of text");

endmodule

### sv/swr_queue.sv
// Short command queue between front and back end.
// Depends on swr_pkg for the entry type and depth.
module swr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  swr_pkg::entry_type    push_entry,
   input  logic                  pop,
   output logic                  has_space,
   output logic                  head_valid,
   output swr_pkg::entry_type    head_entry
);
   import swr_pkg::*;

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;

   assign has_space  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= QCNT_W'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= QCNT_W'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (has_space || pop))
      else $error("queue overflow");

endmodule

### sv/swr_back.sv
// Back end: expands the queue head into result transfers into the output
// register, one a cycle while that register is free. Depends on swr_pkg.
module swr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  swr_pkg::cfg_type      cfg,
   input  logic                  head_valid,
   input  swr_pkg::entry_type    head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swr_pkg::byte_type     rsp_out_byte,
   output logic                  rsp_byte_present,
   output logic                  rsp_text_done,
   output logic                  rsp_run_last
);
   import swr_pkg::*;

   logic [CNT_W-1:0]  idx_ff;
   logic              rsp_valid_ff;
   byte_type          out_byte_ff;
   logic              byte_present_ff;
   logic              text_done_ff;
   logic              run_last_ff;

   logic              out_free;
   logic              fire;
   logic              at_last;
   logic [CNT_W-1:0]  flush_pos;
   byte_type          out_byte_in;
   logic              byte_present_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = head_valid && out_free;
   assign at_last   = (idx_ff == head_entry.last_idx);
   assign pop       = fire && at_last;
   assign flush_pos = CNT_W'(idx_ff - head_entry.head_count);

   always_comb begin
      out_byte_in     = '0;
      byte_present_in = 1'b1;
      if (head_entry.bare) begin
         byte_present_in = 1'b0;
      end else if (idx_ff < head_entry.head_count) begin
         out_byte_in = head_entry.head_replace ?
                       cfg.replace_word[idx_ff[RIDX_W-1:0]] : head_entry.head_byte;
      end else begin
         out_byte_in = head_entry.flush_bytes[flush_pos[SIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= at_last ? '0 : CNT_W'(idx_ff + 1'b1);
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff     <= out_byte_in;
         byte_present_ff <= byte_present_in;
         run_last_ff     <= at_last;
         text_done_ff    <= at_last && head_entry.eot;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_present = byte_present_ff;
   assign rsp_text_done    = text_done_ff;
   assign rsp_run_last     = run_last_ff;

   // result counter rests at zero between entries
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("result index moved without an entry");

   // counter never runs past the entry's last result
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff <= head_entry.last_idx))
      else $error("result index beyond last result");

endmodule

### sv/stream_word_replace_unit.sv
// Top level of the stream word replace unit: streaming find-and-replace.
// Depends on swr_pkg, swr_csr, swr_front, swr_queue and swr_back.
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+--------------------------------
//   req      | req_valid/req_ready, 2 fields      | one text byte per transfer
//   rsp      | rsp_valid/rsp_ready, 4 fields      | one result byte or end marker
//   csr      | csr_write_enable/index/write_data  | one register write, no stall
//
// Throughput: the back end emits one result transfer per cycle from the
// two-entry command queue while the rsp register is not stalled; a byte
// that yields several results holds the back end until all are out.
// Path: an entry is written into the queue, then its results are
// registered in the output register, which drives rsp_valid.
// Stalls: req_ready drops only while the queue is full; a stalled rsp
// register stops the back end, the front keeps taking bytes until full.
// Reset: synchronous; empties window, queue and output register and loads
// the register reset values. No clearing pass.
module stream_word_replace_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_end_of_text,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_byte_present,
   output logic                              rsp_text_done,
   output logic                              rsp_run_last,

   input  logic                              csr_write_enable,
   input  logic [swr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import swr_pkg::*;

   cfg_type    cfg;
   logic       window_clear;
   logic       req_fire;
   entry_type  push_entry;
   logic       push;
   logic       pop;
   logic       has_space;
   logic       head_valid;
   entry_type  head_entry;

   // front side only waits on queue space
   assign req_ready = has_space;
   assign req_fire  = req_valid && req_ready;

   swr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .window_clear     (window_clear)
   );

   // window update and match happen in the transfer cycle; the entry is
   // captured by the queue at the same edge
   swr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .window_clear    (window_clear),
      .req_fire        (req_fire),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .entry           (push_entry),
      .entry_push      (push)
   );

   // bytes that only fill the window push nothing
   swr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .has_space  (has_space),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // replacement bytes come from the live registers; the user must change
   // them only while the block is idle, which the block does not enforce
   swr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_text_done    (rsp_text_done),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

### tb/tb_stream_word_replace_unit.sv
// Self-checking testbench for stream_word_replace_unit: streams texts in, checks each result
// transfer against a built-in find-and-replace predictor, with random idling on both sides.
// Depends on swr_pkg and the stream_word_replace_unit RTL.
module tb_stream_word_replace_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import swr_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 8;        // drain margin beyond the last result
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 20;
   localparam int HOLD_CYCLES    = 300;      // long rsp_ready hold-off for the fill test
   localparam int MAX_PRINTED    = 40;
   localparam longint RUN_LIMIT_NS = 5_000_000;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 3'd7;

   localparam byte_type CHAR_A    = 8'h61;
   localparam byte_type CHAR_B    = 8'h62;
   localparam byte_type CHAR_C    = 8'h63;
   localparam byte_type CHAR_X    = 8'h78;
   localparam byte_type CHAR_Y    = 8'h79;
   localparam byte_type CHAR_DASH = 8'h2d;

   typedef struct packed {
      byte_type out_byte;
      logic     byte_present;
      logic     text_done;
      logic     run_last;
   } text_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_text_byte;
   logic                   req_end_of_text;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_byte_present;
   logic                   rsp_text_done;
   logic                   rsp_run_last;
   logic                   csr_write_enable;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // predictor copy of the registers and the match window
   logic [LEN_REG_W-1:0]   cfg_search_len;
   logic [LEN_REG_W-1:0]   cfg_replace_len;
   logic [63:0]            cfg_search_lo;
   logic [63:0]            cfg_search_hi;
   logic [63:0]            cfg_replace_lo;
   logic [63:0]            cfg_replace_hi;
   byte_type               window_bytes [MAX_SEARCH_LEN];
   int                     window_count;

   text_result_type        pending_results [$];
   int                     mismatch_count = 0;

   // idling knobs: per-transfer waits are drawn from 0..max
   int                     send_gap_max   = 0;
   int                     rsp_stall_max  = 0;
   int                     rsp_stall_left = 0;
   int                     rsp_hold_left  = 0;

   stream_word_replace_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_text_done    (rsp_text_done),
      .rsp_run_last     (rsp_run_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic byte_type word_byte(logic [63:0] lo, logic [63:0] hi, int i);
      if (i < 8) return lo[8*i +: 8];
      return hi[8*(i-8) +: 8];
   endfunction

   // zero counts as one, anything past the window depth saturates
   function automatic int search_span();
      if (cfg_search_len == 0) return 1;
      if (cfg_search_len > MAX_SEARCH_LEN) return MAX_SEARCH_LEN;
      return int'(cfg_search_len);
   endfunction

   function automatic text_result_type make_result(byte_type value, logic present);
      text_result_type r;
      r = '{value, present, 1'b0, 1'b0};
      return r;
   endfunction

   task automatic reset_replace_model();
      cfg_search_len  = 5'd1;
      cfg_replace_len = '0;
      cfg_search_lo   = '0;
      cfg_search_hi   = '0;
      cfg_replace_lo  = '0;
      cfg_replace_hi  = '0;
      foreach (window_bytes[i]) window_bytes[i] = '0;
      window_count = 0;
   endtask

   task automatic apply_register(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
         CSR_SEARCH_LENGTH: begin
            cfg_search_len = data[LEN_REG_W-1:0];
            window_count   = 0;              // held bytes are dropped
         end
         CSR_REPLACE_LENGTH: cfg_replace_len = data[LEN_REG_W-1:0];
         CSR_SEARCH_LOW:     cfg_search_lo   = data;
         CSR_SEARCH_HIGH:    cfg_search_hi   = data;
         CSR_REPLACE_LOW:    cfg_replace_lo  = data;
         CSR_REPLACE_HIGH:   cfg_replace_hi  = data;
         default: ;                          // unmapped index: no effect
      endcase
   endtask

   task automatic shift_window(int k);
      if (k >= window_count) begin
         window_count = 0;
      end else begin
         for (int i = 0; i < window_count - k; i++) window_bytes[i] = window_bytes[i+k];
         window_count -= k;
      end
   endtask

   // Works out every result one text byte causes and queues them in order.
   task automatic predict_text_byte(byte_type value, logic last);
      text_result_type run [$];
      int              span;
      int              rlen;
      bit              hit;
      span = search_span();
      rlen = (cfg_replace_len > MAX_REPLACE_LEN) ? MAX_REPLACE_LEN : int'(cfg_replace_len);
      if (window_count < MAX_SEARCH_LEN) begin
         window_bytes[window_count] = value;
         window_count++;
      end
      if (window_count >= span) begin
         hit = 1'b1;
         for (int i = 0; i < span; i++)
            if (window_bytes[i] != word_byte(cfg_search_lo, cfg_search_hi, i)) hit = 1'b0;
         if (hit) begin
            for (int i = 0; i < rlen; i++)
               run.push_back(make_result(word_byte(cfg_replace_lo, cfg_replace_hi, i), 1'b1));
            shift_window(span);
         end else begin
            run.push_back(make_result(window_bytes[0], 1'b1));
            shift_window(1);
         end
      end
      if (last) begin
         for (int i = 0; i < window_count; i++)
            run.push_back(make_result(window_bytes[i], 1'b1));
         window_count = 0;
         if (run.size() == 0) run.push_back(make_result(8'h00, 1'b0));   // bare end marker
      end
      if (run.size() > 0) begin
         run[run.size()-1].run_last = 1'b1;
         if (last) run[run.size()-1].text_done = 1'b1;
      end
      foreach (run[i]) pending_results.push_back(run[i]);
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // one req transfer; called and returns at a falling edge, valid left high
   task automatic send_byte(byte_type value, logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      predict_text_byte(value, last);
      req_valid       <= 1'b1;
      req_text_byte   <= value;
      req_end_of_text <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // register writes lower the enable after each write so it is never re-raised in one step
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      apply_register(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_words(logic [63:0] slen, logic [63:0] rlen, logic [63:0] s_lo,
                             logic [63:0] s_hi, logic [63:0] r_lo, logic [63:0] r_hi);
      write_reg(CSR_SEARCH_LENGTH, slen);
      write_reg(CSR_REPLACE_LENGTH, rlen);
      write_reg(CSR_SEARCH_LOW, s_lo);
      write_reg(CSR_SEARCH_HIGH, s_hi);
      write_reg(CSR_REPLACE_LOW, r_lo);
      write_reg(CSR_REPLACE_HIGH, r_hi);
   endtask

   // Waits until every expected result has come, then lets the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Hold-offs first, then short random stalls after each result transfer.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: every rsp transfer against the oldest expectation.
   always @(posedge clock) begin : check_results
      text_result_type got;
      text_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_byte, rsp_byte_present, rsp_text_done, rsp_run_last};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transfer", 32'(got), 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (got.out_byte !== want.out_byte)
               report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
            if (got.byte_present !== want.byte_present)
               report_mismatch("byte_present", 32'(got.byte_present),
                               32'(want.byte_present));
            if (got.text_done !== want.text_done)
               report_mismatch("text_done", 32'(got.text_done), 32'(want.text_done));
            if (got.run_last !== want.run_last)
               report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
         end
         rsp_stall_left = $urandom_range(0, rsp_stall_max);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // biased toward a two-letter alphabet so random words actually match
   function automatic byte_type draw_text_byte();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1) ? CHAR_A : CHAR_B;
      return byte_type'($urandom_range(0, 255));
   endfunction

   function automatic int pick_idle_max();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 18;
      endcase
   endfunction

   task automatic load_random_words();
      logic [63:0] slen;
      logic [63:0] rlen;
      logic [63:0] s_lo;
      logic [63:0] s_hi;
      slen = {$urandom, $urandom};
      rlen = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       slen[4:0] = 5'd0;
         1:       slen[4:0] = 5'd1;
         2:       slen[4:0] = 5'd16;
         3:       slen[4:0] = 5'($urandom_range(17, 31));
         default: slen[4:0] = 5'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 3))
         0:       rlen[4:0] = 5'd0;
         1:       rlen[4:0] = 5'd16;
         2:       rlen[4:0] = 5'd31;
         default: rlen[4:0] = 5'($urandom_range(0, 31));
      endcase
      for (int i = 0; i < 8; i++) begin
         s_lo[8*i +: 8] = draw_text_byte();
         s_hi[8*i +: 8] = draw_text_byte();
      end
      load_words(slen, rlen, s_lo, s_hi, {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   // Texts made of spliced-in copies of the search word, whole or cut short,
   // mixed with noise bytes; every text closes with its end flag.
   task automatic send_random_texts(int budget);
      int left;
      int text_len;
      int k;
      int span;
      int cut;
      left = budget;
      span = search_span();
      while (left > 0) begin
         text_len = $urandom_range(1, 2 * span + 8);
         if (text_len > left) text_len = left;
         k = 0;
         while (k < text_len) begin
            if ($urandom_range(0, 2) == 0) begin
               cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
               for (int j = 0; j < cut && k < text_len; j++) begin
                  send_byte(word_byte(cfg_search_lo, cfg_search_hi, j), k == text_len - 1);
                  k++;
               end
            end else begin
               send_byte(draw_text_byte(), k == text_len - 1);
               k++;
            end
         end
         left -= text_len;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // After reset the word is one zero byte with an empty replacement: zeros vanish.
   task automatic test_reset_values();
      send_byte(8'h00, 1'b1);        // deleted byte on the last item gives a bare end marker
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);        // no result at all for this one
      send_byte(8'hff, 1'b1);
      settle();
   endtask

   // Zero search length acts as one, replace length 31 saturates to 16.
   task automatic test_length_saturation();
      load_words(64'hffff_ffff_ffff_ffe0, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_00ff,
                 64'h0, 64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef);
      send_byte(8'hff, 1'b0);        // full 16-byte expansion
      send_byte(8'h80, 1'b0);
      send_byte(8'hff, 1'b1);
      settle();
   endtask

   // A length write with bytes held in the window throws those bytes away.
   task automatic test_length_write_mid_text();
      load_words(64'd31, 64'd2, {$urandom, $urandom}, {$urandom, $urandom},
                 64'h0000_0000_0000_5a5a, 64'h0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      settle();
      write_reg(CSR_SEARCH_LENGTH, 64'd2);
      write_reg(CSR_SEARCH_LOW, {48'h0, CHAR_Y, CHAR_X});
      send_byte(CHAR_X, 1'b0);
      send_byte(CHAR_Y, 1'b1);
      settle();
   endtask

   // Writes to unmapped indexes must leave every register alone.
   task automatic test_unused_index();
      write_reg(CSR_UNUSED_LOW, '1);
      write_reg(CSR_UNUSED_HIGH, '1);
      send_byte(CHAR_X, 1'b0);
      send_byte(CHAR_Y, 1'b0);
      send_byte(8'h41, 1'b1);
      settle();
   endtask

   // End flag with a partly filled window, after a match, and on a near miss.
   task automatic test_flush_at_end();
      load_words(64'd3, 64'd1, {40'h0, CHAR_C, CHAR_B, CHAR_A}, 64'h0, {56'h0, CHAR_DASH}, 64'h0);
      send_byte(CHAR_A, 1'b0);
      send_byte(CHAR_B, 1'b1);
      send_byte(CHAR_A, 1'b0);
      send_byte(CHAR_B, 1'b0);
      send_byte(CHAR_C, 1'b0);
      send_byte(CHAR_A, 1'b0);
      send_byte(CHAR_B, 1'b0);
      send_byte(CHAR_X, 1'b1);
      settle();
   endtask

   task automatic test_random_texts();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_random_words();
         send_gap_max  = pick_idle_max();
         rsp_stall_max = pick_idle_max();
         send_random_texts(PHASE_ITEMS);
         settle();
      end
   endtask

   // Receiver holds off for a long stretch while expansions pile up, so req_ready drops.
   task automatic test_input_stall();
      load_words(64'd2, 64'd16, {48'h0, CHAR_B, CHAR_A}, 64'h0,
                 {$urandom, $urandom}, {$urandom, $urandom});
      send_gap_max  = 0;
      rsp_stall_max = 0;
      @(posedge clock);
      rsp_hold_left = HOLD_CYCLES;
      @(negedge clock);
      for (int i = 0; i < 30; i++) send_byte((i % 2 == 0) ? CHAR_A : CHAR_B, i == 29);
      settle();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_text_byte    = '0;
      req_end_of_text  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SEARCH_LENGTH;
      csr_write_data   = '0;
      reset_replace_model();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_length_saturation();
      test_length_write_mid_text();
      test_unused_index();
      test_flush_at_end();
      test_random_texts();
      test_input_stall();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("status: fail");
      $finish;
   end

endmodule

### files.f
sv/swr_pkg.sv
sv/swr_csr.sv
sv/swr_front.sv
sv/swr_queue.sv
sv/swr_back.sv
sv/stream_word_replace_unit.sv
tb/tb_stream_word_replace_unit.sv
